// ===== design/heap_sorter_macros.svh =====
// ---------------------------------------------------------------------------
// Heap sorter assertion macros
// Shared concurrent assertion templates for the heap sorter.
// ---------------------------------------------------------------------------
`ifndef HEAP_SORTER_MACROS_SVH
`define HEAP_SORTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hs_pkg.sv =====
// ---------------------------------------------------------------------------
// Heap sorter package
// Shared constants, controller states and status bundle of the heap sorter.
// ---------------------------------------------------------------------------
package hs_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned DataW        = 32;

  typedef enum logic [3:0] {
    StIdle,
    StBldRd,
    StBldX,
    StSwRd0,
    StSwRdK,
    StSwWr,
    StSiftL,
    StSiftR,
    StSiftCmp,
    StOut
  } hs_state_e;

  typedef struct packed {
    logic busy;
    logic result_valid;
    logic last_result;
    logic overflow;
  } hs_status_t;

endpackage

// ===== design/heap_sorter.sv =====
// ---------------------------------------------------------------------------
// Heap sorter
// Collects a set of signed values and streams it back in ascending order.
// ---------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction  Handshake
//  input     start_i, value_i, last_item_i             in         start_i & !busy_o
//  config    max_heap_mode_we_i, max_heap_mode_i       in         write enable
//  result    result_valid_o, sorted_value_o,           out        strobe, one cycle
//            last_result_o, overflow_o
//
// While a set is being loaded the block takes one input transaction per cycle
// and busy_o stays low. The transaction marked last raises busy_o and starts
// the sort, which runs out of the element memory over its single read port:
// each heap level steps through a left read, a right read and a compare and
// write back, each heap root through a read and a load of the value, and each
// extraction swap through a root read, a tail read and a write back.
// Results come out on consecutive cycles, one per stored value; busy_o drops
// in the cycle that shows the final result, and the next set may start then.
// Reset clears the fill count, the drop flag and the controller state; the
// memory is not cleared, since only entries written for the current set are
// ever read. The receiver cannot stall the result stream.
//
// The sift-down keeps the value being moved in a register and only writes it
// back at its final position, so each level needs a single memory write.
// ---------------------------------------------------------------------------
`include "heap_sorter_macros.svh"

module heap_sorter #(
  parameter int unsigned DEPTH = hs_pkg::DefaultDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [hs_pkg::DataW-1:0] value_i,
  input  logic                            last_item_i,
  input  logic                            max_heap_mode_we_i,
  input  logic                            max_heap_mode_i,
  output logic                            result_valid_o,
  output logic signed [hs_pkg::DataW-1:0] sorted_value_o,
  output logic                            last_result_o,
  output logic                            overflow_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                            mode_q;
  logic                            ram_we;
  logic [IW-1:0]                   ram_waddr, ram_raddr;
  logic signed [hs_pkg::DataW-1:0] ram_wdata, ram_rdata;
  hs_pkg::hs_status_t              status;

  // Heap kind register. The controller samples it when the set is closed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (max_heap_mode_we_i) begin
      mode_q <= max_heap_mode_i;
    end
  end

  hs_ram #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hs_ctrl #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .last_item_i (last_item_i),
    .mode_i      (mode_q),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata),
    .status_o    (status)
  );

  assign busy_o         = status.busy;
  assign result_valid_o = status.result_valid;
  assign last_result_o  = status.last_result;
  assign overflow_o     = status.overflow;
  // Read data is registered in the memory and lines up with the strobe.
  assign sorted_value_o = ram_rdata;

  // A result only follows a cycle in which the sorter was busy.
  `HS_ASSERT_SAME(a_result_after_busy, clk_i, rst_ni, result_valid_o, $past(busy_o), "result without sort")
  // Closing a set always starts a sort.
  `HS_ASSERT_NEXT(a_last_starts_sort, clk_i, rst_ni, start_i && !busy_o && last_item_i, busy_o, "last item did not start sort")
  // Loading a value that does not close the set keeps the block ready.
  `HS_ASSERT_NEXT(a_load_stays_idle, clk_i, rst_ni, start_i && !busy_o && !last_item_i, !busy_o, "load raised busy")
  // The final result ends the sort.
  `HS_ASSERT_SAME(a_last_ends_sort, clk_i, rst_ni, last_result_o, result_valid_o && !busy_o, "last result while busy")

endmodule

// ===== design/hs_ram.sv =====
// ---------------------------------------------------------------------------
// Heap sorter element memory
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module hs_ram #(
  parameter int unsigned DEPTH = hs_pkg::DefaultDepth,
  parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [IW-1:0]                   waddr_i,
  input  logic signed [hs_pkg::DataW-1:0] wdata_i,
  input  logic [IW-1:0]                   raddr_i,
  output logic signed [hs_pkg::DataW-1:0] rdata_o
);

  logic signed [hs_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [hs_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hs_ctrl.sv =====
// ---------------------------------------------------------------------------
// Heap sorter controller
// Loads the set, runs heap build and extraction over the memory, streams out.
// ---------------------------------------------------------------------------
module hs_ctrl #(
  parameter int unsigned DEPTH = hs_pkg::DefaultDepth,
  parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [hs_pkg::DataW-1:0] value_i,
  input  logic                            last_item_i,
  input  logic                            mode_i,
  output logic                            we_o,
  output logic [IW-1:0]                   waddr_o,
  output logic signed [hs_pkg::DataW-1:0] wdata_o,
  output logic [IW-1:0]                   raddr_o,
  input  logic signed [hs_pkg::DataW-1:0] rdata_i,
  output hs_pkg::hs_status_t              status_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = IW + 2;

  typedef logic signed [hs_pkg::DataW-1:0] data_t;

  function automatic logic before_f(input data_t a, input data_t b, input logic maxh);
    return maxh ? (a > b) : (a < b);
  endfunction

  hs_pkg::hs_state_e state_q, state_d, as_state;

  logic [CW-1:0] fill_q, fill_d, n_q, n_d, k_q, k_d, hn_q, hn_d, idx_q, idx_d;
  logic [CW-1:0] as_k, k_m1, n_m1, n_ent, n_half, pos;
  logic          drop_q, drop_d, mode_q, mode_d, phase_q, phase_d, as_phase;
  logic          valid_q, valid_d, last_q, last_d, ovf_q, ovf_d;
  logic [IW-1:0] cur_q, cur_d;
  data_t         x_q, x_d, lv_q, lv_d, pv, pick_val;
  logic [LW-1:0] l_c, r_c;
  logic          l_ok, r_ok, l_bef, r_bef, moves, accept, has_room;
  logic [IW-1:0] pick_idx;

  assign accept   = start_i && (state_q == hs_pkg::StIdle);
  assign has_room = fill_q < CW'(DEPTH);
  assign n_ent    = has_room ? (fill_q + CW'(1)) : fill_q;
  assign n_half   = n_ent >> 1;
  assign k_m1     = k_q - CW'(1);
  assign n_m1     = n_q - CW'(1);

  assign l_c   = {1'b0, cur_q, 1'b1};
  assign r_c   = l_c + LW'(1);
  assign l_ok  = l_c < LW'(hn_q);
  assign r_ok  = r_c < LW'(hn_q);
  assign l_bef = before_f(lv_q, x_q, mode_q);
  assign pv    = l_bef ? lv_q : x_q;
  assign r_bef = r_ok && before_f(rdata_i, pv, mode_q);
  assign moves = l_bef || r_bef;
  assign pick_idx = r_bef ? r_c[IW-1:0] : l_c[IW-1:0];
  assign pick_val = r_bef ? rdata_i : lv_q;
  assign pos      = mode_q ? idx_q : (n_m1 - idx_q);

  // Where the controller goes once a sift-down has placed its value.
  always_comb begin
    if (!phase_q && (k_q != CW'(1))) begin
      as_k     = k_m1;
      as_phase = 1'b0;
      as_state = hs_pkg::StBldRd;
    end else begin
      as_k     = phase_q ? k_m1 : n_m1;
      as_phase = 1'b1;
      as_state = (as_k == '0) ? hs_pkg::StOut : hs_pkg::StSwRd0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hs_pkg::StIdle: begin
        if (accept && last_item_i) begin
          state_d = (n_half != '0) ? hs_pkg::StBldRd : hs_pkg::StOut;
        end
      end
      hs_pkg::StBldRd:   state_d = hs_pkg::StBldX;
      hs_pkg::StBldX:    state_d = hs_pkg::StSiftL;
      hs_pkg::StSwRd0:   state_d = hs_pkg::StSwRdK;
      hs_pkg::StSwRdK:   state_d = hs_pkg::StSwWr;
      hs_pkg::StSwWr:    state_d = hs_pkg::StSiftL;
      hs_pkg::StSiftL:   state_d = l_ok ? hs_pkg::StSiftR : as_state;
      hs_pkg::StSiftR:   state_d = hs_pkg::StSiftCmp;
      hs_pkg::StSiftCmp: state_d = moves ? hs_pkg::StSiftL : as_state;
      hs_pkg::StOut:     state_d = (idx_q == n_m1) ? hs_pkg::StIdle : hs_pkg::StOut;
      default:           state_d = hs_pkg::StIdle;
    endcase
  end

  always_comb begin
    fill_d  = fill_q;
    drop_d  = drop_q;
    mode_d  = mode_q;
    phase_d = phase_q;
    n_d     = n_q;
    k_d     = k_q;
    hn_d    = hn_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    x_d     = x_q;
    lv_d    = lv_q;
    valid_d = 1'b0;
    last_d  = 1'b0;
    ovf_d   = 1'b0;
    we_o    = 1'b0;
    waddr_o = cur_q;
    wdata_o = x_q;
    raddr_o = '0;
    unique case (state_q)
      hs_pkg::StIdle: begin
        if (accept) begin
          if (has_room) begin
            we_o    = 1'b1;
            waddr_o = fill_q[IW-1:0];
            wdata_o = value_i;
            fill_d  = n_ent;
          end else begin
            drop_d = 1'b1;
          end
          if (last_item_i) begin
            mode_d = mode_i;
            n_d    = n_ent;
            idx_d  = '0;
            if (n_half != '0) begin
              k_d     = n_half;
              phase_d = 1'b0;
            end else begin
              k_d     = n_ent - CW'(1);
              phase_d = 1'b1;
            end
          end
        end
      end
      hs_pkg::StBldRd: begin
        raddr_o = k_m1[IW-1:0];
      end
      hs_pkg::StBldX: begin
        x_d   = rdata_i;
        cur_d = k_m1[IW-1:0];
        hn_d  = n_q;
      end
      hs_pkg::StSwRd0: begin
        raddr_o = '0;
      end
      hs_pkg::StSwRdK: begin
        raddr_o = k_q[IW-1:0];
        lv_d    = rdata_i;
      end
      hs_pkg::StSwWr: begin
        // The old root goes to the tail; the tail value sifts down from the top.
        x_d     = rdata_i;
        we_o    = 1'b1;
        waddr_o = k_q[IW-1:0];
        wdata_o = lv_q;
        cur_d   = '0;
        hn_d    = k_q;
      end
      hs_pkg::StSiftL: begin
        if (l_ok) begin
          raddr_o = l_c[IW-1:0];
        end else begin
          we_o    = 1'b1;
          k_d     = as_k;
          phase_d = as_phase;
        end
      end
      hs_pkg::StSiftR: begin
        lv_d = rdata_i;
        if (r_ok) begin
          raddr_o = r_c[IW-1:0];
        end
      end
      hs_pkg::StSiftCmp: begin
        we_o = 1'b1;
        if (moves) begin
          wdata_o = pick_val;
          cur_d   = pick_idx;
        end else begin
          k_d     = as_k;
          phase_d = as_phase;
        end
      end
      hs_pkg::StOut: begin
        raddr_o = pos[IW-1:0];
        valid_d = 1'b1;
        last_d  = (idx_q == n_m1);
        ovf_d   = drop_q;
        idx_d   = idx_q + CW'(1);
        if (idx_q == n_m1) begin
          fill_d = '0;
          drop_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hs_pkg::StIdle;
      fill_q  <= '0;
      drop_q  <= 1'b0;
      valid_q <= 1'b0;
      phase_q <= 1'b0;
      k_q     <= '0;
      n_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      valid_q <= valid_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    hn_q   <= hn_d;
    cur_q  <= cur_d;
    x_q    <= x_d;
    lv_q   <= lv_d;
    last_q <= last_d;
    ovf_q  <= ovf_d;
  end

  assign status_o.busy         = (state_q != hs_pkg::StIdle);
  assign status_o.result_valid = valid_q;
  assign status_o.last_result  = last_q;
  assign status_o.overflow     = ovf_q;

endmodule
